FILE: design/sfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sfr_pkg;

    localparam int BYTE_W    = 8;
    localparam int CFG_W     = 64;
    localparam int LEN_W     = 4;
    localparam int CFG_IDX_W = 2;
    // run count of one queued job, 0..8 bytes
    localparam int RUN_CNT_W = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_BYTES      = 2'd0,
        REG_PATTERN_LENGTH     = 2'd1,
        REG_REPLACEMENT_BYTES  = 2'd2,
        REG_REPLACEMENT_LENGTH = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [CFG_W-1:0] pattern_bytes;
        logic [LEN_W-1:0] pattern_length;
        logic [CFG_W-1:0] replacement_bytes;
        logic [LEN_W-1:0] replacement_length;
    } cfg_t;

    // control part of one job handed from the front to the back
    typedef struct packed {
        logic [RUN_CNT_W-1:0] count;
        logic                 last;
    } job_ctl_t;

endpackage

`default_nettype wire

FILE: design/sfr_front.sv
`timescale 1ns / 1ps
`default_nettype none

module sfr_front
    import sfr_pkg::*;
#(
    parameter int MAX_PATTERN     = 8,
    parameter int MAX_REPLACEMENT = 8,
    parameter int MAX_RUN         = 8
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire cfg_t                           cfg,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [BYTE_W-1:0]              in_byte,
    input  wire logic                           in_last,
    input  wire logic                           queue_full,
    output logic                                push,
    output logic [MAX_RUN-1:0][BYTE_W-1:0]      job_bytes,
    output job_ctl_t                            job_ctl
);

    localparam int HW = $clog2(MAX_PATTERN + 1);

    logic [MAX_PATTERN-1:0][BYTE_W-1:0] window_reg, window_next;
    logic [HW-1:0]                      held_reg, held_next;

    logic [HW-1:0]                      p_eff;
    logic [HW-1:0]                      keep;
    logic [HW-1:0]                      drop;
    logic [HW-1:0]                      held_kept;
    logic [HW-1:0]                      fill;
    logic [RUN_CNT_W-1:0]               r_eff;
    logic [MAX_PATTERN-1:0][BYTE_W-1:0] shifted;
    logic [MAX_PATTERN-1:0][BYTE_W-1:0] ins;
    logic                               full;
    logic                               hit;
    logic                               accept;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    // effective lengths, out-of-range settings clamped
    always_comb
    begin
        if (cfg.pattern_length == '0)
            p_eff = HW'(1);
        else if (cfg.pattern_length > LEN_W'(MAX_PATTERN))
            p_eff = HW'(MAX_PATTERN);
        else
            p_eff = HW'(cfg.pattern_length);

        if (cfg.replacement_length > LEN_W'(MAX_REPLACEMENT))
            r_eff = RUN_CNT_W'(MAX_REPLACEMENT);
        else
            r_eff = RUN_CNT_W'(cfg.replacement_length);
    end

    // window update: drop excess after a pattern shrink, then insert the byte
    always_comb
    begin
        keep = p_eff - HW'(1);
        if (held_reg > keep)
        begin
            drop      = held_reg - keep;
            held_kept = keep;
        end
        else
        begin
            drop      = '0;
            held_kept = held_reg;
        end

        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            shifted[i] = '0;
            for (int k = 0; k < MAX_PATTERN; k++)
            begin
                if (k == i + int'(drop))
                    shifted[i] = window_reg[k];
            end
        end

        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if (HW'(i) == held_kept)
                ins[i] = in_byte;
            else
                ins[i] = shifted[i];
        end

        fill = held_kept + HW'(1);
        full = (fill == p_eff);

        hit = full;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if (HW'(i) < p_eff && ins[i] != cfg.pattern_bytes[i*BYTE_W +: BYTE_W])
                hit = 1'b0;
        end
    end

    // classify the transaction into one job for the back end
    always_comb
    begin
        job_ctl.last = in_last;
        for (int i = 0; i < MAX_RUN; i++)
        begin
            job_bytes[i] = '0;
            if (hit)
            begin
                if (i < MAX_REPLACEMENT)
                    job_bytes[i] = cfg.replacement_bytes[i*BYTE_W +: BYTE_W];
            end
            else if (i < MAX_PATTERN)
            begin
                job_bytes[i] = ins[i];
            end
        end

        if (hit)
            job_ctl.count = r_eff;
        else if (full)
            job_ctl.count = in_last ? RUN_CNT_W'(p_eff) : RUN_CNT_W'(1);
        else
            job_ctl.count = in_last ? RUN_CNT_W'(fill) : '0;

        push = accept && (job_ctl.count != '0 || in_last);
    end

    always_comb
    begin
        window_next = window_reg;
        held_next   = held_reg;
        if (accept)
        begin
            if (hit || in_last)
            begin
                window_next = ins;
                held_next   = '0;
            end
            else if (full)
            begin
                for (int i = 0; i < MAX_PATTERN; i++)
                    window_next[i] = (i + 1 < MAX_PATTERN) ? ins[(i + 1) % MAX_PATTERN] : '0;
                held_next = keep;
            end
            else
            begin
                window_next = ins;
                held_next   = fill;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            held_reg   <= '0;
        end
        else
        begin
            window_reg <= window_next;
            held_reg   <= held_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/sfr_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module sfr_queue
    import sfr_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      head,
    output logic                  empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (push && !pop)
            count_next = count_reg + CW'(1);
        else if (pop && !push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/sfr_back.sv
`timescale 1ns / 1ps
`default_nettype none

module sfr_back
    import sfr_pkg::*;
#(
    parameter int MAX_RUN = 8
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           job_avail,
    input  wire logic [MAX_RUN-1:0][BYTE_W-1:0] job_bytes,
    input  wire job_ctl_t                       job_ctl,
    output logic                                pop,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [BYTE_W-1:0]                   out_byte,
    output logic                                out_byte_valid,
    output logic                                out_run_last,
    output logic                                out_stream_end
);

    localparam int IW = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;

    logic [IW-1:0]     idx_reg, idx_next;
    logic              valid_reg, valid_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic              bv_reg, bv_next;
    logic              rl_reg, rl_next;
    logic              se_reg, se_next;
    logic              out_free;
    logic              step;
    logic              final_item;

    assign out_free = !valid_reg || out_ready;
    assign step     = out_free && job_avail;

    always_comb
    begin
        final_item = (job_ctl.count == '0) ||
                     (RUN_CNT_W'(idx_reg) == job_ctl.count - RUN_CNT_W'(1));
        pop        = step && final_item;

        idx_next   = idx_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        bv_next    = bv_reg;
        rl_next    = rl_reg;
        se_next    = se_reg;

        if (out_free)
            valid_next = 1'b0;

        if (step)
        begin
            valid_next = 1'b1;
            rl_next    = final_item;
            se_next    = final_item && job_ctl.last;
            // an empty job is the end marker of a stream whose final job left no byte
            if (job_ctl.count == '0)
            begin
                byte_next = '0;
                bv_next   = 1'b0;
            end
            else
            begin
                byte_next = job_bytes[idx_reg];
                bv_next   = 1'b1;
            end
            idx_next = final_item ? '0 : idx_reg + IW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        bv_reg   <= bv_next;
        rl_reg   <= rl_next;
        se_reg   <= se_next;
    end

    assign out_valid      = valid_reg;
    assign out_byte       = byte_reg;
    assign out_byte_valid = bv_reg;
    assign out_run_last   = rl_reg;
    assign out_stream_end = se_reg;

endmodule

`default_nettype wire

FILE: design/stream_find_replace.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   | direction | handshake                     | payload
// s_axis    | in        | s_axis_tvalid / s_axis_tready | tdata in_byte, tlast stream_last
// m_axis    | out       | m_axis_tvalid / m_axis_tready | tdata out_byte, tuser, tlast
// cfg       | in        | cfg_we (no wait)              | cfg_addr index, cfg_wdata value
//
// one input byte is taken per cycle unless the queue is full; window update, compare
// and classification happen in that cycle and leave at most one job in a four-entry queue
// the output stage sends one result per cycle while m_axis_tready allows, so a match
// with an n-byte replacement or a flush of n held bytes occupies it for n results
// each result passes through the job queue and then the output register
// reset clears the window and the output valid flag and empties the queue
// either side may stall; the queue absorbs short bursts of multi-byte jobs

module stream_find_replace
    import sfr_pkg::*;
#(
    parameter int MAX_PATTERN     = 8,
    parameter int MAX_REPLACEMENT = 8
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [7:0]           s_axis_tdata,  // [7:0] in_byte
    input  wire logic                 s_axis_tlast,  // stream_last
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [7:0]                m_axis_tdata,  // [7:0] out_byte
    output logic [1:0]                m_axis_tuser,  // [0] byte_valid, [1] run_last
    output logic                      m_axis_tlast,  // stream_end
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [CFG_W-1:0]     cfg_wdata
);

    localparam int MAX_RUN    = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
    localparam int JOB_W      = MAX_RUN * BYTE_W + $bits(job_ctl_t);
    localparam int QUEUE_DEPTH = 4;

    cfg_t cfg_reg, cfg_next;

    logic                           push;
    logic                           pop;
    logic                           queue_full;
    logic                           queue_empty;
    logic [MAX_RUN-1:0][BYTE_W-1:0] push_bytes;
    job_ctl_t                       push_ctl;
    logic [JOB_W-1:0]               head;
    logic [MAX_RUN-1:0][BYTE_W-1:0] head_bytes;
    job_ctl_t                       head_ctl;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index_t'(cfg_addr))
                REG_PATTERN_BYTES:      cfg_next.pattern_bytes      = cfg_wdata;
                REG_PATTERN_LENGTH:     cfg_next.pattern_length     = cfg_wdata[LEN_W-1:0];
                REG_REPLACEMENT_BYTES:  cfg_next.replacement_bytes  = cfg_wdata;
                REG_REPLACEMENT_LENGTH: cfg_next.replacement_length = cfg_wdata[LEN_W-1:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pattern_bytes      <= '0;
            cfg_reg.pattern_length     <= LEN_W'(1);
            cfg_reg.replacement_bytes  <= '0;
            cfg_reg.replacement_length <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    sfr_front #(
        .MAX_PATTERN     (MAX_PATTERN),
        .MAX_REPLACEMENT (MAX_REPLACEMENT),
        .MAX_RUN         (MAX_RUN)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_byte    (s_axis_tdata),
        .in_last    (s_axis_tlast),
        .queue_full (queue_full),
        .push       (push),
        .job_bytes  (push_bytes),
        .job_ctl    (push_ctl)
    );

    sfr_queue #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_bytes, push_ctl}),
        .full      (queue_full),
        .pop       (pop),
        .head      (head),
        .empty     (queue_empty)
    );

    assign head_bytes = head[JOB_W-1:$bits(job_ctl_t)];
    assign head_ctl   = head[$bits(job_ctl_t)-1:0];

    sfr_back #(
        .MAX_RUN (MAX_RUN)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .job_avail      (!queue_empty),
        .job_bytes      (head_bytes),
        .job_ctl        (head_ctl),
        .pop            (pop),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_byte       (m_axis_tdata),
        .out_byte_valid (m_axis_tuser[0]),
        .out_run_last   (m_axis_tuser[1]),
        .out_stream_end (m_axis_tlast)
    );

endmodule

`default_nettype wire

FILE: design/sfr_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module sfr_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic [1:0] m_axis_tuser,
    input wire logic       m_axis_tlast
);

    // a stalled output transaction keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("output changed while stalled");

    // end of stream always closes the run of its input
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[1])
        else $error("stream end without run end");

    // an empty marker only ever appears as the final result of a stream
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast && m_axis_tuser[1])
        else $error("empty marker outside stream end");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 8'd0)
        else $error("empty marker carries data");

endmodule

bind stream_find_replace sfr_checker u_sfr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
